/* rtl/tilt_pkg.sv */
`default_nettype none

package tilt_pkg;

	// CORDIC depth and its step counter
	localparam int CORDIC_ITERATIONS = 16;
	localparam int CORDIC_CNT_W      = $clog2(CORDIC_ITERATIONS);
	localparam int ATAN_IDX_W        = 5;

	// datapath widths
	localparam int ANGLE_W   = 17;
	localparam int VEC_W     = 27;
	localparam int Z_W       = 25;
	localparam int ROOT_IN_W = 48;
	localparam int ROOT_W    = 24;
	localparam int MUL_W     = 18;
	localparam int PROD_W    = 36;
	localparam int NUM_W     = 40;
	localparam int DEN_W     = 28;
	localparam int QUO_W     = 16;
	localparam int QCNT_W    = $clog2(QUO_W);
	localparam int DSH_W     = DEN_W + QUO_W - 1;
	localparam int STEP_W    = 3;

	// stream and config port widths
	localparam int S_TDATA_W = 96;
	localparam int M_TDATA_W = 40;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 16;

	// config register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_BLEND_ALPHA = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GYRO_SENS   = 1'd1;

	localparam logic [15:0] ALPHA_RESET = 16'd64225;
	localparam logic [10:0] SENS_RESET  = 11'd1310;
	localparam logic [10:0] SENS_FLOOR  = 11'd164;

	// sens * HALF_SCALE is half of the gyro divisor
	localparam logic [15:0] HALF_SCALE = 16'd50000;
	localparam logic [16:0] ONE_Q16    = 17'h10000;
	localparam logic [15:0] BLEND_ROUND = 16'h8000;
	localparam logic [7:0]  ANGLE_ROUND = 8'h80;

	localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = 17'sd46079;
	localparam logic signed [ANGLE_W-1:0] ANGLE_MIN = -17'sd46080;

	localparam logic [ROOT_IN_W-1:0] ROOT_TOP_BIT = ROOT_IN_W'(1) << (ROOT_IN_W - 2);

	localparam logic [STEP_W-1:0] MUL_LAST   = 3'd6;
	localparam logic [STEP_W-1:0] BLEND_LAST = 3'd4;

	// atan(2^-i) in 1/65536 degree
	function automatic logic signed [Z_W-1:0] atan_step(input logic [ATAN_IDX_W-1:0] idx);
		logic signed [Z_W-1:0] v;
		unique case (idx)
			5'd0:  v = 25'sd2949120;
			5'd1:  v = 25'sd1740967;
			5'd2:  v = 25'sd919879;
			5'd3:  v = 25'sd466945;
			5'd4:  v = 25'sd234379;
			5'd5:  v = 25'sd117304;
			5'd6:  v = 25'sd58666;
			5'd7:  v = 25'sd29335;
			5'd8:  v = 25'sd14668;
			5'd9:  v = 25'sd7334;
			5'd10: v = 25'sd3667;
			5'd11: v = 25'sd1833;
			5'd12: v = 25'sd917;
			5'd13: v = 25'sd458;
			5'd14: v = 25'sd229;
			5'd15: v = 25'sd115;
			5'd16: v = 25'sd57;
			5'd17: v = 25'sd29;
			5'd18: v = 25'sd14;
			5'd19: v = 25'sd7;
			5'd20: v = 25'sd4;
			5'd21: v = 25'sd2;
			5'd22: v = 25'sd1;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

/* rtl/tilt_mul.sv */
`default_nettype none

// shared signed multiplier, product registered
module tilt_mul
	import tilt_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic signed [MUL_W-1:0]  a,
	input  wire logic signed [MUL_W-1:0]  b,
	output logic signed [PROD_W-1:0]      p
);
	logic signed [PROD_W-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= PROD_W'(a) * PROD_W'(b);
	end

	assign p = p_q;

endmodule

`default_nettype wire

/* rtl/tilt_root.sv */
`default_nettype none

// bit-pair square root, floor, one result bit a cycle
module tilt_root
	import tilt_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic [ROOT_IN_W-1:0] radicand,
	output logic                      busy,
	output logic [ROOT_W-1:0]         root
);
	logic [ROOT_IN_W-1:0] rem_q;
	logic [ROOT_IN_W-1:0] res_q;
	logic [ROOT_IN_W-1:0] bit_q;
	logic                 busy_q;
	logic [ROOT_IN_W:0]   trial;
	logic                 take;

	assign trial = {1'b0, res_q} + {1'b0, bit_q};
	assign take  = {1'b0, rem_q} >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (busy_q && bit_q[0]) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= radicand;
			res_q <= '0;
			bit_q <= ROOT_TOP_BIT;
		end else if (busy_q) begin
			if (take) begin
				rem_q <= rem_q - trial[ROOT_IN_W-1:0];
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign busy = busy_q;
	assign root = res_q[ROOT_W-1:0];

endmodule

`default_nettype wire

/* rtl/tilt_div.sv */
`default_nettype none

// restoring divider, one quotient bit a cycle, MSB first
module tilt_div
	import tilt_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] dividend,
	input  wire logic [DEN_W-1:0] divisor,
	output logic                  busy,
	output logic [QUO_W-1:0]      quotient
);
	logic [NUM_W-1:0]  rem_q;
	logic [DSH_W-1:0]  dsh_q;
	logic [QUO_W-1:0]  quo_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              busy_q;
	logic              ge;

	assign ge = DSH_W'(rem_q) >= dsh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (busy_q && cnt_q == '0) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			dsh_q <= DSH_W'(divisor) << (QUO_W - 1);
			quo_q <= '0;
			cnt_q <= QCNT_W'(QUO_W - 1);
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - dsh_q[NUM_W-1:0];
			end
			quo_q <= {quo_q[QUO_W-2:0], ge};
			dsh_q <= dsh_q >> 1;
			cnt_q <= cnt_q - 1'b1;
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

/* rtl/tilt_cordic.sv */
`default_nettype none

// vectoring CORDIC, one rotation a cycle; angle in 1/256 degree
module tilt_cordic
	import tilt_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic signed [VEC_W-1:0]  x_in,
	input  wire logic signed [VEC_W-1:0]  y_in,
	output logic                          busy,
	output logic signed [ANGLE_W-1:0]     angle
);
	logic signed [VEC_W-1:0]  x_q;
	logic signed [VEC_W-1:0]  y_q;
	logic signed [Z_W-1:0]    z_q;
	logic [CORDIC_CNT_W-1:0]  i_q;
	logic                     zero_q;
	logic                     busy_q;
	logic signed [VEC_W-1:0]  dx;
	logic signed [VEC_W-1:0]  dy;
	logic signed [Z_W-1:0]    step_angle;
	logic signed [Z_W-1:0]    z_rnd;

	assign dx         = y_q >>> i_q;
	assign dy         = x_q >>> i_q;
	assign step_angle = atan_step(ATAN_IDX_W'(i_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (busy_q && i_q == CORDIC_CNT_W'(CORDIC_ITERATIONS - 1)) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= x_in;
			y_q    <= y_in;
			z_q    <= '0;
			i_q    <= '0;
			zero_q <= (x_in == '0) && (y_in == '0);
		end else if (busy_q) begin
			if (!y_q[VEC_W-1]) begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + step_angle;
			end else begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - step_angle;
			end
			i_q <= i_q + 1'b1;
		end
	end

	// round to nearest 1/256 degree; null vector reads as level
	assign z_rnd = z_q + Z_W'(ANGLE_ROUND);
	assign angle = zero_q ? '0 : z_rnd[Z_W-1:Z_W-ANGLE_W];
	assign busy  = busy_q;

endmodule

`default_nettype wire

/* rtl/imu_complementary_tilt_filter.sv */
`default_nettype none

// Complementary roll/pitch tilt filter. Each item on the s_ stream is one IMU
// sample; each produces one item on the m_ stream carrying the new roll and
// pitch estimates in 1/256 degree, saturated to -180 up to just under +180
// degrees. Roll and pitch from the accelerometer come from a bit-pair square
// root and a vectoring CORDIC; the gyro rate times elapsed time comes from a
// restoring divider; an 18x18 multiplier is shared by every product, blend
// included. The estimates persist between items and clear only on reset.
// s_tready is high only in the idle state, so a new item is taken only once
// the last one has been through the multiply, root, CORDIC and blend steps
// and its result is in the output register, which waits while m_tready holds
// back a previous result. The two 24-step square roots take the longest; the
// divider and the roll CORDIC run alongside them, the pitch CORDIC runs on
// its own. Config writes (index 0 blend alpha, index 1 gyro sensitivity) are
// taken at once and must only be made while no item is in flight.
module imu_complementary_tilt_filter
	import tilt_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// accel_x[15:0], accel_y[31:16], accel_z[47:32], gyro_x[63:48],
	// gyro_y[79:64], elapsed_us[95:80]
	input  wire logic [S_TDATA_W-1:0]  s_tdata,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// roll_angle[16:0], pitch_angle[33:17], zero[39:34]
	output logic [M_TDATA_W-1:0]       m_tdata,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,     // squares, gyro products, divisor
		ST_ROOT_R,  // roll magnitude root, gyro x divide
		ST_CORD_R,  // roll CORDIC, pitch root, gyro y divide
		ST_CORD_P,  // pitch CORDIC
		ST_BLEND,   // four blend products, saturate
		ST_OUT
	} state_t;

	state_t              state_q;
	logic [STEP_W-1:0]   step_q;
	logic                m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;

	logic [15:0] alpha_q;
	logic [10:0] sens_q;
	logic [10:0] sens_c;

	logic signed [ANGLE_W-1:0] est_r_q;
	logic signed [ANGLE_W-1:0] est_p_q;

	// latched sample
	logic [15:0] ax_q, ay_q, az_q, gx_q, gy_q, dt_q;

	// intermediate results
	logic [31:0]               sqr_q;   // ax^2 + az^2
	logic [31:0]               sqp_q;   // ay^2 + az^2
	logic [30:0]               ngx_q;   // |gx| * dt
	logic [30:0]               ngy_q;
	logic [26:0]               half_q;  // sens * 50000
	logic signed [ANGLE_W-1:0] inc_r_q;
	logic signed [ANGLE_W-1:0] inc_p_q;
	logic signed [ANGLE_W-1:0] acc_r_q;
	logic signed [ANGLE_W-1:0] acc_p_q;
	logic signed [PROD_W-1:0]  bl_q;

	// shared multiplier
	logic signed [MUL_W-1:0]  mul_a;
	logic signed [MUL_W-1:0]  mul_b;
	logic signed [PROD_W-1:0] prod;

	// unit handshakes
	logic                     root_start, root_busy;
	logic [ROOT_W-1:0]        root_out;
	logic [ROOT_IN_W-1:0]     root_in;
	logic                     div_start, div_busy;
	logic [QUO_W-1:0]         div_quo;
	logic [NUM_W-1:0]         div_num;
	logic [DEN_W-1:0]         div_den;
	logic                     cord_start, cord_busy;
	logic signed [VEC_W-1:0]  cord_x, cord_y;
	logic signed [ANGLE_W-1:0] cord_angle;
	logic                     start_mul, start_roll, start_pitch;

	logic [16:0]             gxa, gya, beta;
	logic [MUL_W-1:0]        sum_r, sum_p;
	logic signed [VEC_W-1:0] roll_y, pitch_y;
	logic signed [PROD_W:0]  bl_sum;
	logic signed [PROD_W-16:0] bl_shift;
	logic signed [ANGLE_W-1:0] bl_sat;

	function automatic logic signed [ANGLE_W-1:0] signed_inc(input logic [QUO_W-1:0] q,
			input logic neg);
		logic signed [ANGLE_W-1:0] m;
		m = $signed({1'b0, q});
		return neg ? -m : m;
	endfunction

	assign sens_c = (sens_q < SENS_FLOOR) ? SENS_FLOOR : sens_q;

	// magnitudes of the gyro rates; full negative count gives 32768
	assign gxa  = gx_q[15] ? (17'd0 - {1'b1, gx_q}) : {1'b0, gx_q};
	assign gya  = gy_q[15] ? (17'd0 - {1'b1, gy_q}) : {1'b0, gy_q};
	assign beta = ONE_Q16 - {1'b0, alpha_q};

	assign sum_r = {est_r_q[ANGLE_W-1], est_r_q} + {inc_r_q[ANGLE_W-1], inc_r_q};
	assign sum_p = {est_p_q[ANGLE_W-1], est_p_q} + {inc_p_q[ANGLE_W-1], inc_p_q};

	// numerators scaled by 256 for the CORDIC
	assign roll_y  = {{3{ay_q[15]}}, ay_q, 8'h00};
	assign pitch_y = VEC_W'(0) - {{3{ax_q[15]}}, ax_q, 8'h00};

	// operand select for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (state_q == ST_BLEND) begin
			unique case (step_q)
				3'd0: begin mul_a = {2'b00, alpha_q}; mul_b = sum_r; end
				3'd1: begin mul_a = {1'b0, beta}; mul_b = {acc_r_q[ANGLE_W-1], acc_r_q}; end
				3'd2: begin mul_a = {2'b00, alpha_q}; mul_b = sum_p; end
				3'd3: begin mul_a = {1'b0, beta}; mul_b = {acc_p_q[ANGLE_W-1], acc_p_q}; end
				default: ;
			endcase
		end else begin
			unique case (step_q)
				3'd0: begin mul_a = {7'd0, sens_c}; mul_b = {2'b00, HALF_SCALE}; end
				3'd1: begin mul_a = {1'b0, gxa}; mul_b = {2'b00, dt_q}; end
				3'd2: begin mul_a = {1'b0, gya}; mul_b = {2'b00, dt_q}; end
				3'd3: begin mul_a = {{2{ax_q[15]}}, ax_q}; mul_b = {{2{ax_q[15]}}, ax_q}; end
				3'd4: begin mul_a = {{2{az_q[15]}}, az_q}; mul_b = {{2{az_q[15]}}, az_q}; end
				3'd5: begin mul_a = {{2{ay_q[15]}}, ay_q}; mul_b = {{2{ay_q[15]}}, ay_q}; end
				default: ;
			endcase
		end
	end

	// unit launches: roll root and gx divide, then roll CORDIC with pitch root
	// and gy divide, then pitch CORDIC
	assign start_mul   = (state_q == ST_MUL) && (step_q == MUL_LAST);
	assign start_roll  = (state_q == ST_ROOT_R) && !root_busy && !div_busy;
	assign start_pitch = (state_q == ST_CORD_R) && !cord_busy && !root_busy && !div_busy;

	assign root_start = start_mul || start_roll;
	assign div_start  = start_mul || start_roll;
	assign cord_start = start_roll || start_pitch;

	assign root_in = (state_q == ST_MUL) ? {sqr_q, 16'h0000} : {sqp_q, 16'h0000};
	assign div_num = (state_q == ST_MUL) ? ({1'b0, ngx_q, 8'h00} + NUM_W'(half_q))
	                                     : ({1'b0, ngy_q, 8'h00} + NUM_W'(half_q));
	assign div_den = {half_q, 1'b0};
	assign cord_x  = {3'b000, root_out};
	assign cord_y  = (state_q == ST_ROOT_R) ? roll_y : pitch_y;

	// blend: round, floor to 1/256 degree, saturate
	assign bl_sum   = {bl_q[PROD_W-1], bl_q} + {prod[PROD_W-1], prod}
	                + (PROD_W+1)'(BLEND_ROUND);
	assign bl_shift = bl_sum[PROD_W:16];

	always_comb begin
		if (bl_shift > (PROD_W-15)'(ANGLE_MAX)) begin
			bl_sat = ANGLE_MAX;
		end else if (bl_shift < (PROD_W-15)'(ANGLE_MIN)) begin
			bl_sat = ANGLE_MIN;
		end else begin
			bl_sat = bl_shift[ANGLE_W-1:0];
		end
	end

	tilt_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod)
	);

	tilt_root u_root (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (root_start),
		.radicand (root_in),
		.busy     (root_busy),
		.root     (root_out)
	);

	tilt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.busy     (div_busy),
		.quotient (div_quo)
	);

	tilt_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cord_start),
		.x_in   (cord_x),
		.y_in   (cord_y),
		.busy   (cord_busy),
		.angle  (cord_angle)
	);

	// sequencer, config, estimates and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			step_q     <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			alpha_q    <= ALPHA_RESET;
			sens_q     <= SENS_RESET;
			est_r_q    <= '0;
			est_p_q    <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_BLEND_ALPHA: alpha_q <= cfg_data;
					CFG_GYRO_SENS:   sens_q  <= cfg_data[10:0];
				endcase
			end
			// in ST_OUT the output register is reloaded below instead
			if (m_tvalid_q && m_tready && state_q != ST_OUT) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					if (s_tvalid) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (step_q == MUL_LAST) begin
						state_q <= ST_ROOT_R;
						step_q  <= '0;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_ROOT_R: begin
					if (start_roll) begin
						state_q <= ST_CORD_R;
					end
				end
				ST_CORD_R: begin
					if (start_pitch) begin
						state_q <= ST_CORD_P;
					end
				end
				ST_CORD_P: begin
					if (!cord_busy) begin
						state_q <= ST_BLEND;
						step_q  <= '0;
					end
				end
				ST_BLEND: begin
					if (step_q == 3'd2) begin
						est_r_q <= bl_sat;
					end
					if (step_q == BLEND_LAST) begin
						est_p_q <= bl_sat;
						state_q <= ST_OUT;
						step_q  <= '0;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_OUT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {{(M_TDATA_W - 2*ANGLE_W){1'b0}}, est_p_q, est_r_q};
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// data path registers
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			ax_q <= s_tdata[15:0];
			ay_q <= s_tdata[31:16];
			az_q <= s_tdata[47:32];
			gx_q <= s_tdata[63:48];
			gy_q <= s_tdata[79:64];
			dt_q <= s_tdata[95:80];
		end
		if (state_q == ST_MUL) begin
			unique case (step_q)
				3'd1: half_q <= prod[26:0];
				3'd2: ngx_q  <= prod[30:0];
				3'd3: ngy_q  <= prod[30:0];
				3'd4: sqr_q  <= prod[31:0];
				3'd5: begin
					sqr_q <= sqr_q + prod[31:0];
					sqp_q <= prod[31:0];
				end
				3'd6: sqp_q <= sqp_q + prod[31:0];
				default: ;
			endcase
		end
		if (start_roll) begin
			inc_r_q <= signed_inc(div_quo, gx_q[15]);
		end
		if (start_pitch) begin
			acc_r_q <= cord_angle;
			inc_p_q <= signed_inc(div_quo, gy_q[15]);
		end
		if (state_q == ST_CORD_P && !cord_busy) begin
			acc_p_q <= cord_angle;
		end
		if (state_q == ST_BLEND && (step_q == 3'd1 || step_q == 3'd3)) begin
			bl_q <= prod;
		end
	end

	assign s_tready  = (state_q == ST_IDLE);
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign cfg_ready = 1'b1;

`ifndef SYNTHESIS
	a_accept_units_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |-> !(root_busy || div_busy || cord_busy))
		else $error("item taken while a unit is still running");

	a_root_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		root_start |-> !root_busy)
		else $error("square root restarted mid-run");

	a_div_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider restarted mid-run");

	a_cord_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cord_start |-> !cord_busy)
		else $error("CORDIC restarted mid-run");

	a_est_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(est_r_q >= ANGLE_MIN) && (est_r_q <= ANGLE_MAX)
		&& (est_p_q >= ANGLE_MIN) && (est_p_q <= ANGLE_MAX))
		else $error("estimate outside saturation range");
`endif

endmodule

`default_nettype wire
